// ----- rtl/slpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_pkg - shared types and constants of the servo long packet framer
// Command codes, command record and the fixed byte tables of the packets.
// ----------------------------------------------------------------------------
package slpf_pkg;

    // command kinds queued from front to back
    localparam logic [1:0] KIND_TORQUE = 2'd0;
    localparam logic [1:0] KIND_OPEN   = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;

    // byte steps of a motion packet
    localparam logic [3:0] STEP_HDR0  = 4'd0;
    localparam logic [3:0] STEP_CNT   = 4'd6;
    localparam logic [3:0] STEP_ID    = 4'd7;
    localparam logic [3:0] STEP_POSL  = 4'd8;
    localparam logic [3:0] STEP_POSH  = 4'd9;
    localparam logic [3:0] STEP_TIML  = 4'd10;
    localparam logic [3:0] STEP_TIMH  = 4'd11;
    localparam logic [3:0] STEP_SUM   = 4'd12;
    localparam logic [3:0] STEP_SUMD0 = 4'd2;   // first byte inside the checksum
    localparam logic [3:0] TQ_LAST    = 4'd9;

    localparam logic [7:0] BYTE_SYNC0 = 8'hFA;
    localparam logic [7:0] BYTE_SYNC1 = 8'hAF;
    localparam logic [7:0] BYTE_ADDR  = 8'h1E;
    localparam logic [7:0] BYTE_LEN   = 8'h05;

    typedef logic [7:0] t_byte;

    localparam t_byte TQ_PKT [10] = '{
        8'hFA, 8'hAF, 8'h00, 8'h00, 8'h24, 8'h02, 8'h01, 8'h01, 8'h01, 8'h27
    };

    typedef struct packed {
        logic [1:0]         kind;
        logic               close;      // checksum follows this command
        logic [7:0]         cnt;
        logic [7:0]         id;
        logic signed [15:0] pos;
        logic signed [15:0] tim;
    } t_cmd;

    // header bytes of a motion packet, steps 0 to 6
    function automatic t_byte hdr_byte(input logic [3:0] step, input t_byte cnt);
        t_byte b;
        b = 8'h00;
        case (step)
            4'd0:    b = BYTE_SYNC0;
            4'd1:    b = BYTE_SYNC1;
            4'd4:    b = BYTE_ADDR;
            4'd5:    b = BYTE_LEN;
            4'd6:    b = cnt;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/slpf_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_intf - channel interfaces of the servo long packet framer
// Input entry channel and output byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slpf_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         servo_id;
    logic signed [15:0] target_position;
    logic signed [15:0] move_time;
    logic [7:0]         entry_count;

    modport source (output valid, opcode, servo_id, target_position, move_time,
                    entry_count, input ready);
    modport sink   (input valid, opcode, servo_id, target_position, move_time,
                    entry_count, output ready);
endinterface

interface slpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;

    modport source (output valid, out_byte, packet_end, input ready);
    modport sink   (input valid, out_byte, packet_end, output ready);
endinterface

// ----- rtl/slpf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_front - entry classifier
// Tracks the open packet and turns each transfer into a queued command.
// ----------------------------------------------------------------------------
module slpf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slpf_in_if.sink       i_in,
    input  logic          i_full,
    output logic          o_push,
    output slpf_pkg::t_cmd o_cmd
);
    import slpf_pkg::*;

    logic       r_in_packet, n_in_packet;
    logic [7:0] r_left, n_left;
    logic       take;

    assign i_in.ready = !i_full;
    assign take       = i_in.valid && !i_full;

    always_comb begin
        n_in_packet = r_in_packet;
        n_left      = r_left;
        o_push      = 1'b0;
        o_cmd.kind  = KIND_ENTRY;
        o_cmd.close = 1'b0;
        o_cmd.cnt   = i_in.entry_count;
        o_cmd.id    = i_in.servo_id;
        o_cmd.pos   = i_in.target_position;
        o_cmd.tim   = i_in.move_time;
        if (take) begin
            if (i_in.opcode) begin
                // torque request is dropped while a packet is open
                o_push     = !r_in_packet;
                o_cmd.kind = KIND_TORQUE;
            end else if (!r_in_packet) begin
                o_push      = 1'b1;
                o_cmd.kind  = KIND_OPEN;
                o_cmd.close = (i_in.entry_count <= 8'd1);
                n_in_packet = (i_in.entry_count > 8'd1);
                n_left      = i_in.entry_count - 8'd1;
            end else begin
                o_push      = 1'b1;
                o_cmd.close = (r_left == 8'd1);
                n_in_packet = (r_left != 8'd1);
                n_left      = r_left - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_left      <= 8'd0;
        end else begin
            r_in_packet <= n_in_packet;
            r_left      <= n_left;
        end
    end

endmodule

// ----- rtl/slpf_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_cmd_fifo - command queue
// Short register queue between classifier and byte sequencer.
// ----------------------------------------------------------------------------
module slpf_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slpf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output slpf_pkg::t_cmd o_cmd
);
    import slpf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

endmodule

// ----- rtl/slpf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_back - byte sequencer
// Steps commands one byte a cycle, unless stalled, into the output register.
// ----------------------------------------------------------------------------
module slpf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  slpf_pkg::t_cmd i_cmd,
    output logic           o_pop,
    slpf_out_if.source     o_out
);
    import slpf_pkg::*;

    t_cmd       r_cmd;
    logic       r_busy;
    logic [3:0] r_step;
    t_byte      r_xor;
    logic       r_ov, r_oe;
    t_byte      r_ob;

    logic       adv, last, is_end, summed, torque;
    t_byte      cur;
    logic [3:0] n_step;

    assign torque = (r_cmd.kind == KIND_TORQUE);
    assign adv    = r_busy && (!r_ov || o_out.ready);

    always_comb begin
        cur    = 8'h00;
        is_end = 1'b0;
        last   = 1'b0;
        summed = 1'b0;
        n_step = r_step + 4'd1;
        unique case (r_cmd.kind)
            KIND_TORQUE: begin
                cur    = TQ_PKT[(r_step > TQ_LAST) ? TQ_LAST : r_step];
                is_end = (r_step == TQ_LAST);
                last   = is_end;
            end
            KIND_OPEN, KIND_ENTRY: begin
                summed = (r_step >= STEP_SUMD0) && (r_step <= STEP_TIMH);
                case (r_step)
                    STEP_ID:   cur = r_cmd.id;
                    STEP_POSL: cur = r_cmd.pos[7:0];
                    STEP_POSH: cur = r_cmd.pos[15:8];
                    STEP_TIML: cur = r_cmd.tim[7:0];
                    STEP_TIMH: cur = r_cmd.tim[15:8];
                    STEP_SUM:  cur = r_xor;
                    default:   cur = hdr_byte(r_step, r_cmd.cnt);
                endcase
                is_end = (r_step == STEP_SUM);
                last   = is_end || ((r_step == STEP_TIMH) && !r_cmd.close);
                // empty packet: header straight into the checksum
                if ((r_step == STEP_CNT) && (r_cmd.cnt == 8'd0)) n_step = STEP_SUM;
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    assign o_pop = i_valid && (!r_busy || (adv && last));

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        if (adv) begin
            r_ob <= cur;
            r_oe <= is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_HDR0;
            r_xor  <= 8'h00;
            r_ov   <= 1'b0;
        end else begin
            if (adv) begin
                if (!torque && (is_end || r_step == STEP_HDR0)) r_xor <= 8'h00;
                else if (summed)                                r_xor <= r_xor ^ cur;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= (i_cmd.kind == KIND_ENTRY) ? STEP_ID : STEP_HDR0;
            end else if (adv) begin
                r_step <= n_step;
                if (last) r_busy <= 1'b0;
            end
            if (adv)              r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.packet_end = r_oe;

`ifndef SYNTH
    a_motion_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !torque) |-> (r_step <= STEP_SUM))
        else $error("motion step out of range");
    a_torque_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && torque) |-> (r_step <= TQ_LAST))
        else $error("torque step out of range");
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_end && !torque) |=> (r_xor == 8'h00))
        else $error("checksum not cleared after packet end");
`endif

endmodule

// ----- rtl/servo_long_packet_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_long_packet_framer - serial servo long packet builder
// Frames motion entries and torque requests into a checksummed byte stream.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                             | transfer
//  i_in    | in  | opcode, servo_id, target_position, move_time,       | valid & ready
//          |     | entry_count                                         |
//  o_out   | out | out_byte, packet_end                                | valid & ready
//
//  One byte leaves per cycle through the output register while the output is
//  ready; that register sets the rate. A motion entry is 5 bytes, 6 with the
//  checksum, and the opening entry adds 7 header bytes; a torque packet is 10 bytes.
//  Synchronous active-low reset clears the packet state, queue and output.
//  A queue of QUEUE_DEPTH commands lets entries be taken while the output
//  stalls; the input stalls only once the queue is full.
// ----------------------------------------------------------------------------
module servo_long_packet_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slpf_in_if.sink    i_in,
    slpf_out_if.source o_out
);
    import slpf_pkg::*;

    logic full, push, pop, q_valid;
    t_cmd push_cmd, head_cmd;

    // front: tracks open packet, classifies each transfer
    slpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // decoupling queue
    slpf_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // back: byte sequencer and running checksum
    slpf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
